@@ src/nhcl_pkg.sv @@
// ----------------------------------------------------------------------------
// nhcl_pkg
// Shared types and constants for the name hash chain lookup block.
// ----------------------------------------------------------------------------
package nhcl_pkg;

    localparam int NAME_W      = 64;
    localparam int SPACE_W     = 16;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int IDX_OUT_W   = 12;
    localparam int CFG_W       = 13;
    localparam int BKT_W       = 12;
    localparam int BUCKET_SLOTS = 4096;
    localparam int HASH_W      = 17;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [NAME_W-1:0]  name;
        logic [SPACE_W-1:0] space;
        logic [BKT_W-1:0]   bucket;
    } item_t;

endpackage

@@ src/nhcl_fifo.sv @@
// ----------------------------------------------------------------------------
// nhcl_fifo
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module nhcl_fifo
    import nhcl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t pop_item
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ src/nhcl_front.sv @@
// ----------------------------------------------------------------------------
// nhcl_front
// Takes input beats, canonicalises the name, hashes it, reduces the hash of an
// insert or lookup modulo the bucket count one bit a cycle, queues the item.
// ----------------------------------------------------------------------------
module nhcl_front
    import nhcl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    operation,
    input  logic [NAME_W-1:0]  key_name,
    input  logic [SPACE_W-1:0] name_space,
    input  logic [CFG_W-1:0]   bucket_count,
    input  logic               hold,
    output logic               push,
    output item_t              push_item,
    input  logic               full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;
    localparam logic [4:0] DIV_LAST = 5'(HASH_W - 1);

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    item_t             item_reg;
    item_t             item_next;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [BKT_W-1:0]  rem_reg;
    logic [BKT_W-1:0]  rem_next;
    logic [4:0]        cnt_reg;
    logic [4:0]        cnt_next;

    logic [NAME_W-1:0] canon;
    logic [HASH_W-1:0] hash;
    logic [CFG_W-1:0]  divisor;
    logic [CFG_W-1:0]  part;
    logic              accept;

    always_comb
    begin
        logic stop;
        logic [7:0] b;
        canon = '0;
        stop  = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            b = key_name[8*i +: 8];
            if (b == 8'd0)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                if (b >= 8'h61 && b <= 8'h7a)
                begin
                    b = b - 8'h20;
                end
                canon[8*i +: 8] = b;
            end
        end
    end

    always_comb
    begin
        logic stop;
        hash = HASH_W'(canon[7:0]);
        stop = (canon[15:8] == 8'd0);
        if (!stop)
        begin
            hash = {hash[HASH_W-2:0], 1'b0} + hash + HASH_W'(canon[15:8]);
        end
        for (int i = 2; i <= 6; i++)
        begin
            if (canon[8*i +: 8] == 8'd0)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                hash = {hash[HASH_W-2:0], 1'b0} + HASH_W'(canon[8*i +: 8]);
            end
        end
        if (!stop)
        begin
            hash = {hash[HASH_W-2:0], 1'b0} + HASH_W'(canon[63:56]);
        end
    end

    always_comb
    begin
        if (bucket_count == '0)
        begin
            divisor = CFG_W'(1);
        end
        else if (bucket_count > CFG_W'(BUCKET_SLOTS))
        begin
            divisor = CFG_W'(BUCKET_SLOTS);
        end
        else
        begin
            divisor = bucket_count;
        end
    end

    assign in_ready  = (state_reg == F_IDLE) && !hold;
    assign accept    = in_valid && in_ready;
    assign push      = (state_reg == F_PUSH) && !full;
    assign push_item = item_reg;
    assign part      = {rem_reg, hash_reg[HASH_W-1]};

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        hash_next  = hash_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    item_next.op     = operation;
                    item_next.name   = canon;
                    item_next.space  = name_space;
                    item_next.bucket = '0;
                    hash_next        = hash;
                    rem_next         = '0;
                    cnt_next         = '0;
                    if (operation == OP_INSERT || operation == OP_LOOKUP)
                    begin
                        state_next = F_DIV;
                    end
                    else
                    begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_DIV:
            begin
                hash_next = {hash_reg[HASH_W-2:0], 1'b0};
                if (part >= divisor)
                begin
                    rem_next = BKT_W'(part - divisor);
                end
                else
                begin
                    rem_next = BKT_W'(part);
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    item_next.bucket = rem_next;
                    state_next       = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        hash_reg <= hash_next;
        rem_reg  <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ src/nhcl_back.sv @@
// ----------------------------------------------------------------------------
// nhcl_back
// Executes queued items against the entry and bucket memories, walks chains
// one entry a cycle and holds the result in an output register.
// ----------------------------------------------------------------------------
module nhcl_back
    import nhcl_pkg::*;
#(
    parameter int MAX_ENTRIES = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fifo_valid,
    input  item_t                fifo_item,
    output logic                 pop,
    output logic                 init_busy,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [IDX_OUT_W-1:0] entry_index
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] B_INIT = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_HEAD = 3'd2;
    localparam logic [2:0] B_HVAL = 3'd3;
    localparam logic [2:0] B_VAL  = 3'd4;
    localparam logic [2:0] B_CMP  = 3'd5;

    logic [NAME_W-1:0]  names_mem  [MAX_ENTRIES];
    logic [SPACE_W-1:0] spaces_mem [MAX_ENTRIES];
    logic [IW:0]        links_mem  [MAX_ENTRIES];
    logic [BKT_W-1:0]   ebkt_mem   [MAX_ENTRIES];
    logic [IW-1:0]      heads_mem  [BUCKET_SLOTS];

    logic [NAME_W-1:0]  names_rd_reg;
    logic [SPACE_W-1:0] spaces_rd_reg;
    logic [IW:0]        links_rd_reg;
    logic [BKT_W-1:0]   ebkt_rd_reg;
    logic [IW-1:0]      heads_rd_reg;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    item_t                item_reg;
    item_t                item_next;
    logic [IW-1:0]        cur_reg;
    logic [IW-1:0]        cur_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [BKT_W-1:0]     init_reg;
    logic [BKT_W-1:0]     init_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [IDX_OUT_W-1:0] index_reg;
    logic [IDX_OUT_W-1:0] index_next;

    logic [IW-1:0]        ent_addr;
    logic                 ent_we;
    logic                 head_we;
    logic [BKT_W-1:0]     head_waddr;
    logic [IW-1:0]        head_wdata;
    logic                 hv;
    logic                 done;
    logic [STATUS_W-1:0]  res_status;
    logic [IW-1:0]        res_idx;
    logic [IW+IDX_OUT_W-1:0] res_ext;

    assign init_busy   = (state_reg == B_INIT);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_index = index_reg;
    assign res_ext     = {{IDX_OUT_W{1'b0}}, res_idx};

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        init_next  = init_reg;
        ent_addr   = cur_reg;
        ent_we     = 1'b0;
        head_we    = 1'b0;
        head_waddr = item_reg.bucket;
        head_wdata = count_reg[IW-1:0];
        pop        = 1'b0;
        done       = 1'b0;
        res_status = ST_MISS;
        res_idx    = '0;
        hv         = (state_reg == B_CMP)
                  || ((CW'(cur_reg) < count_reg) && (ebkt_rd_reg == item_reg.bucket));
        case (state_reg)
            B_INIT:
            begin
                head_we    = 1'b1;
                head_waddr = init_reg;
                head_wdata = '0;
                init_next  = init_reg + BKT_W'(1);
                if (init_reg == {BKT_W{1'b1}})
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (fifo_valid && !out_valid_reg)
                begin
                    pop       = 1'b1;
                    item_next = fifo_item;
                    case (fifo_item.op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            done       = 1'b1;
                            res_status = ST_OK;
                        end
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(MAX_ENTRIES))
                            begin
                                done       = 1'b1;
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                state_next = B_HEAD;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            state_next = B_HEAD;
                        end
                        default:
                        begin
                            done       = 1'b1;
                            res_status = ST_MISS;
                        end
                    endcase
                end
            end
            B_HEAD:
            begin
                state_next = B_HVAL;
            end
            B_HVAL:
            begin
                ent_addr   = heads_rd_reg;
                cur_next   = heads_rd_reg;
                state_next = B_VAL;
            end
            B_VAL, B_CMP:
            begin
                state_next = B_IDLE;
                if (item_reg.op == OP_INSERT)
                begin
                    ent_we     = 1'b1;
                    head_we    = 1'b1;
                    count_next = count_reg + CW'(1);
                    done       = 1'b1;
                    res_status = ST_OK;
                    res_idx    = count_reg[IW-1:0];
                end
                else if (!hv)
                begin
                    done = 1'b1;
                end
                else if (names_rd_reg == item_reg.name && spaces_rd_reg == item_reg.space)
                begin
                    done       = 1'b1;
                    res_status = ST_OK;
                    res_idx    = cur_reg;
                end
                else if (links_rd_reg[IW])
                begin
                    ent_addr   = links_rd_reg[IW-1:0];
                    cur_next   = links_rd_reg[IW-1:0];
                    state_next = B_CMP;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        index_next     = index_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
            status_next    = res_status;
            index_next     = (res_status == ST_OK) ? res_ext[IDX_OUT_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            names_mem[count_reg[IW-1:0]]  <= item_reg.name;
            spaces_mem[count_reg[IW-1:0]] <= item_reg.space;
            links_mem[count_reg[IW-1:0]]  <= {hv, cur_reg};
            ebkt_mem[count_reg[IW-1:0]]   <= item_reg.bucket;
        end
        names_rd_reg  <= names_mem[ent_addr];
        spaces_rd_reg <= spaces_mem[ent_addr];
        links_rd_reg  <= links_mem[ent_addr];
        ebkt_rd_reg   <= ebkt_mem[ent_addr];
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            heads_mem[head_waddr] <= head_wdata;
        end
        heads_rd_reg <= heads_mem[item_reg.bucket];
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        index_reg  <= index_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            count_reg     <= '0;
            init_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/name_hash_chain_lookup_top.sv @@
// ----------------------------------------------------------------------------
// name_hash_chain_lookup_top
// Chained hash table of 8-byte names tagged with a namespace.
//
// Input channel (in_valid/in_ready) carries one beat per item: operation,
// key_name, name_space. Output channel (out_valid/out_ready) returns one beat
// per item: status and entry_index. bucket_count is written over the APB
// port at address 0; the user must write it only while the block is idle,
// as the block itself does not enforce this. The front part hashes the name
// and reduces it modulo the bucket count one bit a cycle; a clear skips the
// reduction. The back part reads the bucket head, then the entry it names;
// an insert links a new entry in as the chain head, a lookup compares and
// walks the chain to a match or its end. After reset the bucket head memory
// is swept over every slot, with no input beat taken meanwhile. A stalled
// output holds its beat; a two-entry queue lets the front keep taking items.
// ----------------------------------------------------------------------------
module name_hash_chain_lookup_top
    import nhcl_pkg::*;
#(
    parameter int MAX_ENTRIES = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OP_W-1:0]      operation,
    input  logic [NAME_W-1:0]    key_name,
    input  logic [SPACE_W-1:0]   name_space,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [IDX_OUT_W-1:0] entry_index,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [CFG_W-1:0] bucket_count_reg;
    logic             cfg_we;
    logic             push;
    item_t            push_item;
    logic             full;
    logic             pop;
    logic             not_empty;
    item_t            pop_item;
    logic             init_busy;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == 1'b0);
    assign prdata = (paddr == 1'b0) ? {{(32-CFG_W){1'b0}}, bucket_count_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= CFG_W'(BUCKET_SLOTS);
        end
        else if (cfg_we)
        begin
            bucket_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    nhcl_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .key_name     (key_name),
        .name_space   (name_space),
        .bucket_count (bucket_count_reg),
        .hold         (init_busy),
        .push         (push),
        .push_item    (push_item),
        .full         (full)
    );

    nhcl_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_item  (pop_item)
    );

    nhcl_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_valid  (not_empty),
        .fifo_item   (pop_item),
        .pop         (pop),
        .init_busy   (init_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_index (entry_index)
    );

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (entry_index == '0))
        else $error("index not zero on failed result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_MISS || status == ST_FULL))
        else $error("bad status code");

    a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> !in_ready)
        else $error("input taken during head sweep");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");

endmodule
